/* sv/rlfw_pkg.sv */
// Shared types and constants for the recursive lock with a FIFO wait queue.
`default_nettype none
package rlfw_pkg;

  // Sizing
  localparam int THREAD_COUNT = 16;
  localparam int WAIT_DEPTH   = 16;
  localparam int NEST_BITS    = 16;
  localparam int TID_W        = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int FILL_W       = $clog2(WAIT_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 4;

  typedef logic [TID_W-1:0]     tid_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [NEST_BITS-1:0] nest_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_TRY     = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 4'd0,
    ST_NESTED     = 4'd1,
    ST_QUEUED     = 4'd2,
    ST_BUSY       = 4'd3,
    ST_PARTIAL    = 4'd4,
    ST_FREED      = 4'd5,
    ST_HANDED     = 4'd6,
    ST_NOT_OWNER  = 4'd7,
    ST_QUEUE_FULL = 4'd8,
    ST_NEST_OVF   = 4'd9
  } status_t;

  // Per-cell control: shift toward the head, or load the pushed id
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Queue control from the lock controller
  typedef struct packed {
    logic  push;
    logic  pop;
    fill_t fill;
  } queue_ctrl_t;

endpackage
`default_nettype wire

/* sv/recursive_lock_fifo_waiters_top.sv */
// Top level: recursive lock controller, wait-queue cell chain and result register.
// Recursive lock with a first-in first-out queue of blocked threads. Each request
// (acquire, try-acquire or release from a numbered thread) yields exactly one
// result carrying a status code, the woken waiter if the lock was handed over,
// the owner's nesting depth and the number of waiters. The controller decides
// against the owner, depth and fill registers in the cycle of the transfer, and
// the queue is a chain of cells that shifts one step toward the head on each
// handover, so a new request can be taken every cycle while the result register
// is not stalled. A single output register holds the result; a request is taken
// whenever that register is empty or being drained in the same cycle.
`default_nettype none
module recursive_lock_fifo_waiters_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rlfw_pkg::ACTION_W-1:0]   in_action,
  input  wire rlfw_pkg::tid_t                  in_thread_id,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [rlfw_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_woken_valid,
  output rlfw_pkg::tid_t                       out_woken_thread,
  output rlfw_pkg::nest_t                      out_nesting_depth,
  output rlfw_pkg::fill_t                      out_waiter_count
);
  import rlfw_pkg::*;

  // Lock state
  logic  owner_valid_r, owner_valid_nxt;
  tid_t  owner_id_r,    owner_id_nxt;
  nest_t nest_r,        nest_nxt;
  fill_t fill_r,        fill_nxt;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  status_t status_r,    status_nxt;
  logic    woken_v_r,   woken_v_nxt;
  tid_t    woken_t_r,   woken_t_nxt;
  nest_t   depth_r,     depth_nxt;
  fill_t   count_r,     count_nxt;

  logic        in_xfer;
  logic        is_owner;
  status_t     status_c;
  logic        woken_v_c;
  tid_t        woken_t_c;
  queue_ctrl_t q_ctrl;
  tid_t        head_tid;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign is_owner = owner_valid_r && (owner_id_r == in_thread_id);

  // Decide the request; a free lock is exactly one without an owner
  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    nest_nxt        = nest_r;
    fill_nxt        = fill_r;
    status_c        = ST_BUSY;
    woken_v_c       = 1'b0;
    woken_t_c       = '0;
    q_ctrl.push     = 1'b0;
    q_ctrl.pop      = 1'b0;
    q_ctrl.fill     = fill_r;
    if (in_xfer) begin
      case (in_action)
        ACT_ACQUIRE, ACT_TRY: begin
          if (is_owner) begin
            if (nest_r == '1) begin
              status_c = ST_NEST_OVF;
            end else begin
              nest_nxt = nest_r + NEST_BITS'(1);
              status_c = ST_NESTED;
            end
          end else if (!owner_valid_r) begin
            owner_valid_nxt = 1'b1;
            owner_id_nxt    = in_thread_id;
            nest_nxt        = NEST_BITS'(1);
            status_c        = ST_GRANTED;
          end else if (in_action == ACT_TRY) begin
            status_c = ST_BUSY;
          end else if (fill_r >= FILL_W'(WAIT_DEPTH)) begin
            status_c = ST_QUEUE_FULL;
          end else begin
            q_ctrl.push = 1'b1;
            fill_nxt    = fill_r + FILL_W'(1);
            status_c    = ST_QUEUED;
          end
        end
        ACT_RELEASE: begin
          if (!is_owner) begin
            status_c = ST_NOT_OWNER;
          end else if (nest_r > NEST_BITS'(1)) begin
            nest_nxt = nest_r - NEST_BITS'(1);
            status_c = ST_PARTIAL;
          end else if (fill_r != '0) begin
            q_ctrl.pop   = 1'b1;
            fill_nxt     = fill_r - FILL_W'(1);
            woken_v_c    = 1'b1;
            woken_t_c    = head_tid;
            owner_id_nxt = head_tid;
            nest_nxt     = NEST_BITS'(1);
            status_c     = ST_HANDED;
          end else begin
            owner_valid_nxt = 1'b0;
            owner_id_nxt    = '0;
            nest_nxt        = '0;
            status_c        = ST_FREED;
          end
        end
        default: begin
          status_c = ST_BUSY;
        end
      endcase
    end
  end

  rlfw_queue u_queue (
    .clk      (clk),
    .ctrl     (q_ctrl),
    .push_tid (in_thread_id),
    .head_tid (head_tid)
  );

  // Load the result on a transfer, hold it while stalled, drop it once taken
  always_comb begin
    status_nxt  = status_r;
    woken_v_nxt = woken_v_r;
    woken_t_nxt = woken_t_r;
    depth_nxt   = depth_r;
    count_nxt   = count_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      status_nxt    = status_c;
      woken_v_nxt   = woken_v_c;
      woken_t_nxt   = woken_t_c;
      depth_nxt     = nest_nxt;
      count_nxt     = fill_nxt;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      nest_r        <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
      nest_r        <= nest_nxt;
      fill_r        <= fill_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    woken_v_r <= woken_v_nxt;
    woken_t_r <= woken_t_nxt;
    depth_r   <= depth_nxt;
    count_r   <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_woken_valid   = woken_v_r;
  assign out_woken_thread  = woken_t_r;
  assign out_nesting_depth = depth_r;
  assign out_waiter_count  = count_r;

endmodule
`default_nettype wire

/* sv/rlfw_cell.sv */
// One wait-queue cell: holds a thread id, takes its neighbor's on a pop.
`default_nettype none
module rlfw_cell (
  input  wire logic                clk,
  input  wire rlfw_pkg::cell_ctrl_t ctrl,
  input  wire rlfw_pkg::tid_t      push_tid,
  input  wire rlfw_pkg::tid_t      nbr_tid,
  output rlfw_pkg::tid_t           tid
);
  import rlfw_pkg::*;

  tid_t tid_r;
  tid_t tid_nxt;

  // Advance from the neighbor on a pop, load the new waiter on a push
  always_comb begin
    tid_nxt = tid_r;
    if (ctrl.shift) begin
      tid_nxt = nbr_tid;
    end else if (ctrl.load) begin
      tid_nxt = push_tid;
    end
  end

  always_ff @(posedge clk) begin
    tid_r <= tid_nxt;
  end

  assign tid = tid_r;

endmodule
`default_nettype wire

/* sv/rlfw_queue.sv */
// Wait queue built as a chain of cells; cell zero is always the oldest waiter.
`default_nettype none
module rlfw_queue (
  input  wire logic                 clk,
  input  wire rlfw_pkg::queue_ctrl_t ctrl,
  input  wire rlfw_pkg::tid_t       push_tid,
  output rlfw_pkg::tid_t            head_tid
);
  import rlfw_pkg::*;

  tid_t       cell_tid [WAIT_DEPTH];
  tid_t       nbr_tid  [WAIT_DEPTH];
  cell_ctrl_t cell_ctrl[WAIT_DEPTH];

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    // Feed each cell from its tail-side neighbor; the last cell takes zero
    if (i == WAIT_DEPTH - 1) begin : g_last
      assign nbr_tid[i] = '0;
    end else begin : g_mid
      assign nbr_tid[i] = cell_tid[i+1];
    end

    // Push lands in the first empty cell, which is the one at the fill count
    assign cell_ctrl[i].shift = ctrl.pop;
    assign cell_ctrl[i].load  = ctrl.push && (ctrl.fill == FILL_W'(i));

    rlfw_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .push_tid (push_tid),
      .nbr_tid  (nbr_tid[i]),
      .tid      (cell_tid[i])
    );
  end

  assign head_tid = cell_tid[0];

endmodule
`default_nettype wire
